FILE: hw/rtl/mhd_pkg.sv
// Shared types, constants and decode helpers for the message header deframer.
// No dependencies; used by message_header_deframer and mhd_checker.

package mhd_pkg;

   // Result kind codes
   typedef enum logic [1:0] {
      KIND_PAYLOAD     = 2'd0,
      KIND_EMPTY       = 2'd1,
      KIND_MAGIC_ERR   = 2'd2,
      KIND_VERSION_ERR = 2'd3
   } kind_type;

   // Configuration register indexes
   localparam logic CSR_EXPECTED_MAJOR = 1'b0;
   localparam logic CSR_EXPECTED_MINOR = 1'b1;

   localparam logic [7:0] MAJOR_RESET = 8'd1;
   localparam logic [7:0] MINOR_RESET = 8'd5;

   // Header layout (byte positions)
   localparam logic [4:0] POS_MAGIC_LAST = 5'd3;
   localparam logic [4:0] POS_VER_FIRST  = 5'd5;
   localparam logic [4:0] POS_VER_LAST   = 5'd10;
   localparam logic [4:0] POS_LEN_FIRST  = 5'd12;
   localparam logic [4:0] POS_LEN_LAST   = 5'd19;
   localparam logic [4:0] POS_HDR_LAST   = 5'd20;

   // Expected magic text, one byte per header position 0..3
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'h73;
         2'd1:    b = 8'h43;
         2'd2:    b = 8'h6F;
         default: b = 8'h50;
      endcase
      return b;
   endfunction

   // Upper-case hex digit to nibble; anything else reads as zero
   function automatic logic [3:0] hex_value(input logic [7:0] b);
      logic [3:0] v;
      v = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         v = 4'(b - 8'h30);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         v = 4'(b - 8'h37);
      end
      return v;
   endfunction

endpackage

FILE: hw/rtl/message_header_deframer.sv
// Message header deframer: parses a 21-byte text header from a byte stream
// and passes the payload on. Depends on mhd_pkg.

// Channel   Direction  Handshake           Payload
// req       in         req_valid/stall     req_in_byte
// rsp       out        rsp_valid/stall     rsp_kind, rsp_data_byte, rsp_last,
//                                          rsp_message_length
// csr       in         csr_write_en        csr_index, csr_wdata
//
// One request per cycle while req_stall is low; a byte is parsed in the
// cycle it is accepted and any result lands in the output or skid register.
// A two-entry output stage (output register plus skid register) lets requests
// flow while a result waits; req_stall rises only when the skid entry is full.
// Reset (synchronous) restores the version registers to 1.5 and restarts
// header parsing at byte 0. Only write configuration while idle (unenforced).

module message_header_deframer (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_last,
   output logic [31:0] rsp_message_length,
   // configuration
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic        last;
      logic [31:0] message_length;
   } result_type;

   // configuration registers
   logic [7:0]  exp_major_ff, exp_minor_ff;

   // parser state
   logic [4:0]  hdr_pos_ff,      hdr_pos_in;
   logic        magic_good_ff,   magic_good_in;
   logic [23:0] ver_accum_ff,    ver_accum_in;
   logic [31:0] len_accum_ff,    len_accum_in;
   logic [31:0] payload_left_ff, payload_left_in;
   logic        in_payload_ff,   in_payload_in;

   // output stage
   logic        out_valid_ff,  skid_valid_ff;
   result_type  out_data_ff,   skid_data_ff;

   logic        accept;
   logic        take;
   logic        res_valid;
   result_type  res;

   assign accept    = req_valid && !req_stall;
   assign take      = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_data_ff.kind;
   assign rsp_data_byte      = out_data_ff.data_byte;
   assign rsp_last           = out_data_ff.last;
   assign rsp_message_length = out_data_ff.message_length;

   // Parse one byte: next parser state and the result it causes
   always_comb begin
      hdr_pos_in      = hdr_pos_ff;
      magic_good_in   = magic_good_ff;
      ver_accum_in    = ver_accum_ff;
      len_accum_in    = len_accum_ff;
      payload_left_in = payload_left_ff;
      in_payload_in   = in_payload_ff;
      res_valid       = 1'b0;
      res             = '0;

      if (in_payload_ff) begin
         // pass the byte on; the final one closes the message
         res_valid          = 1'b1;
         res.kind           = mhd_pkg::KIND_PAYLOAD;
         res.data_byte      = req_in_byte;
         res.message_length = len_accum_ff;
         if (payload_left_ff <= 32'd1) begin
            res.last        = 1'b1;
            hdr_pos_in      = '0;
            magic_good_in   = 1'b1;
            ver_accum_in    = '0;
            len_accum_in    = '0;
            payload_left_in = '0;
            in_payload_in   = 1'b0;
         end else begin
            payload_left_in = payload_left_ff - 32'd1;
         end
      end else begin
         if (hdr_pos_ff <= mhd_pkg::POS_MAGIC_LAST) begin
            if (req_in_byte != mhd_pkg::magic_byte(hdr_pos_ff[1:0])) begin
               magic_good_in = 1'b0;
            end
         end else if (hdr_pos_ff >= mhd_pkg::POS_VER_FIRST &&
                      hdr_pos_ff <= mhd_pkg::POS_VER_LAST) begin
            ver_accum_in = {ver_accum_ff[19:0], mhd_pkg::hex_value(req_in_byte)};
         end else if (hdr_pos_ff >= mhd_pkg::POS_LEN_FIRST &&
                      hdr_pos_ff <= mhd_pkg::POS_LEN_LAST) begin
            len_accum_in = {len_accum_ff[27:0], mhd_pkg::hex_value(req_in_byte)};
         end

         if (hdr_pos_ff != mhd_pkg::POS_HDR_LAST) begin
            hdr_pos_in = hdr_pos_ff + 5'd1;
         end else begin
            // judge the header: magic first, then version, then length
            res.message_length = len_accum_ff;
            res.last           = 1'b1;
            if (!magic_good_ff) begin
               res_valid = 1'b1;
               res.kind  = mhd_pkg::KIND_MAGIC_ERR;
            end else if (ver_accum_ff[23:16] != exp_major_ff ||
                         ver_accum_ff[15:8]  != exp_minor_ff) begin
               res_valid = 1'b1;
               res.kind  = mhd_pkg::KIND_VERSION_ERR;
            end else if (len_accum_ff == 32'd0) begin
               res_valid = 1'b1;
               res.kind  = mhd_pkg::KIND_EMPTY;
            end

            if (res_valid) begin
               // restart on error or empty message
               hdr_pos_in      = '0;
               magic_good_in   = 1'b1;
               ver_accum_in    = '0;
               len_accum_in    = '0;
               payload_left_in = '0;
               in_payload_in   = 1'b0;
            end else begin
               hdr_pos_in      = '0;
               payload_left_in = len_accum_ff;
               in_payload_in   = 1'b1;
            end
         end
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_major_ff <= mhd_pkg::MAJOR_RESET;
         exp_minor_ff <= mhd_pkg::MINOR_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            mhd_pkg::CSR_EXPECTED_MAJOR: exp_major_ff <= csr_wdata;
            mhd_pkg::CSR_EXPECTED_MINOR: exp_minor_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Parser state: advance only on an accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_pos_ff      <= '0;
         magic_good_ff   <= 1'b1;
         ver_accum_ff    <= '0;
         len_accum_ff    <= '0;
         payload_left_ff <= '0;
         in_payload_ff   <= 1'b0;
      end else if (accept) begin
         hdr_pos_ff      <= hdr_pos_in;
         magic_good_ff   <= magic_good_in;
         ver_accum_ff    <= ver_accum_in;
         len_accum_ff    <= len_accum_in;
         payload_left_ff <= payload_left_in;
         in_payload_ff   <= in_payload_in;
      end
   end

   // Output register and skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // no request accepted here; drain skid into the output on a take
         if (take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || take) begin
         out_valid_ff <= accept && res_valid;
      end else if (accept && res_valid) begin
         // output still held: park the new result
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (!out_valid_ff || take) begin
         if (accept && res_valid) begin
            out_data_ff <= res;
         end
      end else if (accept && res_valid) begin
         skid_data_ff <= res;
      end
   end

endmodule

FILE: hw/rtl/mhd_checker.sv
// Port-level checker for message_header_deframer, attached by bind.
// Depends on mhd_pkg.

module mhd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_data_byte,
   input logic        rsp_last,
   input logic [31:0] rsp_message_length
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) &&
         $stable(rsp_data_byte) && $stable(rsp_last) && $stable(rsp_message_length))
      else $error("stalled result changed");

   // every done or error result closes its message
   a_nonpayload_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != mhd_pkg::KIND_PAYLOAD |-> rsp_last)
      else $error("non-payload result without last");

   // only payload results carry data
   a_nonpayload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != mhd_pkg::KIND_PAYLOAD |-> rsp_data_byte == 8'd0)
      else $error("non-payload result with data");

   // an empty message reports zero length
   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == mhd_pkg::KIND_EMPTY |-> rsp_message_length == 32'd0)
      else $error("empty message with non-zero length");

endmodule

bind message_header_deframer mhd_checker u_mhd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_kind           (rsp_kind),
   .rsp_data_byte      (rsp_data_byte),
   .rsp_last           (rsp_last),
   .rsp_message_length (rsp_message_length)
);
